// ----- sv/tws_pkg.sv -----
// Shared types and constants for the trie word store.
// No dependencies; imported by every module of the block.
package tws_pkg;

  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int OP_W              = 2;
  localparam int LETTER_W          = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PREFIX = 2'd3
  } op_t;

  typedef struct packed {
    logic found;
    logic path_missing;
    logic pool_full;
  } result_t;

endpackage

// ----- sv/trie_word_store_top.sv -----
// Trie word store: letter-at-a-time prefix tree over a fixed node pool.
// Each word takes a link-RAM read, then the cursor update; a finishing word
// adds the mark-RAM read/write, and an empty word goes straight to that step.
// The result is registered into out_valid from FINISH, which holds while the
// previous result is unclaimed. Reset is synchronous; afterwards a clearing sweep
// over all NODE_COUNT*ALPHABET_SIZE link slots zeroes both RAMs before in_ready.
module trie_word_store_top
  import tws_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_word_empty,
  input  logic                in_last_letter,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic                out_path_missing,
  output logic                out_pool_full
);

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,    // waiting for a word
    ST_LOOKUP,  // link read data is back; step the cursor
    ST_FINISH   // mark read data is back; build result
  } state_t;

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [FREE_W-1:0] next_free_r, next_free_nxt;
  logic              failed_r, failed_nxt;
  logic              overflow_r, overflow_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;
  // per-word payload, no reset needed
  op_t               op_r, op_nxt;
  logic              last_r, last_nxt;
  logic              ltr_ok_r, ltr_ok_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // ---------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------
  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  logic              link_wr_en, link_rd_en;
  logic [SLOT_W-1:0] link_wr_addr, link_rd_addr;
  logic [NODE_W-1:0] link_wr_data, link_rd_data;

  logic              mark_wr_en, mark_rd_en;
  logic [NODE_W-1:0] mark_wr_addr, mark_rd_addr;
  logic              mark_wr_data, mark_rd_data;

  // walker-side writes, muxed with the clear sweep below
  logic              walk_link_we, walk_mark_we, walk_mark_wd;

  logic              accept;
  logic              skip;
  logic              finish_fire;
  logic              ltr_in_range;
  logic [SLOT_W-1:0] slot_in;
  result_t           res;

  tws_clear #(.DEPTH(SLOT_DEPTH)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  tws_ram #(.WIDTH(NODE_W), .DEPTH(SLOT_DEPTH)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

  tws_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_ram (
    .clk     (clk),
    .wr_en   (mark_wr_en),
    .wr_addr (mark_wr_addr),
    .wr_data (mark_wr_data),
    .rd_en   (mark_rd_en),
    .rd_addr (mark_rd_addr),
    .rd_data (mark_rd_data)
  );

  // Input side is free only in IDLE once the sweep is done. The output
  // register lets a word in while a result still waits downstream.
  assign in_ready = (state_r == ST_IDLE) && !clr_busy;
  assign accept   = in_valid && in_ready;

  assign ltr_in_range = 32'(in_letter) < ALPHABET_SIZE;
  assign slot_in      = SLOT_W'(cursor_r) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(in_letter);

  // Once a word has failed or overflowed, its remaining letters are no-ops.
  assign skip = failed_r || overflow_r;

  // Result as it would leave FINISH
  always_comb begin
    res = '0;
    if (overflow_r) begin
      res.pool_full = 1'b1;
    end else if (failed_r) begin
      res.path_missing = 1'b1;
    end else begin
      case (op_r)
        OP_SEARCH: res.found = mark_rd_data;
        OP_INSERT,
        OP_REMOVE,
        OP_PREFIX: res.found = 1'b1;
        default:   res.found = 1'b1;
      endcase
    end
  end

  assign finish_fire = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------
  // Walker next-state logic
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    next_free_nxt = next_free_r;
    failed_nxt    = failed_r;
    overflow_nxt  = overflow_r;
    out_res_nxt   = out_res_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    ltr_ok_nxt    = ltr_ok_r;
    slot_nxt      = slot_r;

    out_valid_nxt = out_valid_r && !out_ready;

    link_rd_en    = 1'b0;
    link_rd_addr  = slot_in;
    walk_link_we  = 1'b0;
    mark_rd_en    = 1'b0;
    mark_rd_addr  = '0;
    walk_mark_we  = 1'b0;
    walk_mark_wd  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = op_t'(in_op);
          last_nxt = in_last_letter;
          if (in_word_empty) begin
            // empty word: drop any word in progress and act on the root
            cursor_nxt   = '0;
            failed_nxt   = 1'b0;
            overflow_nxt = 1'b0;
            mark_rd_en   = 1'b1;
            mark_rd_addr = '0;
            state_nxt    = ST_FINISH;
          end else begin
            ltr_ok_nxt = ltr_in_range;
            slot_nxt   = slot_in;
            link_rd_en = ltr_in_range && !skip;
            state_nxt  = ST_LOOKUP;
          end
        end
      end

      ST_LOOKUP: begin
        if (!skip) begin
          if (!ltr_ok_r) begin
            failed_nxt = 1'b1;
          end else if (link_rd_data != '0) begin
            cursor_nxt = link_rd_data;
          end else if (op_r != OP_INSERT) begin
            failed_nxt = 1'b1;
          end else if (next_free_r >= FREE_W'(NODE_COUNT)) begin
            overflow_nxt = 1'b1;
          end else begin
            // allocate a fresh node from the bump counter
            walk_link_we  = 1'b1;
            cursor_nxt    = next_free_r[NODE_W-1:0];
            next_free_nxt = next_free_r + FREE_W'(1);
          end
        end
        if (last_r) begin
          mark_rd_en   = 1'b1;
          mark_rd_addr = cursor_nxt;
          state_nxt    = ST_FINISH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_FINISH: begin
        // holds here while the previous result is still unclaimed
        if (finish_fire) begin
          out_res_nxt   = res;
          out_valid_nxt = 1'b1;
          if (!overflow_r && !failed_r) begin
            walk_mark_we = (op_r == OP_INSERT) || (op_r == OP_REMOVE);
            walk_mark_wd = (op_r == OP_INSERT);
          end
          cursor_nxt   = '0;
          failed_nxt   = 1'b0;
          overflow_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Write ports: clear sweep owns them until it is done.
  assign link_wr_en   = clr_busy || walk_link_we;
  assign link_wr_addr = clr_busy ? clr_addr : slot_r;
  assign link_wr_data = clr_busy ? '0 : next_free_r[NODE_W-1:0];

  // mark RAM is shallower; the sweep wraps over it several times
  assign mark_wr_en   = clr_busy || walk_mark_we;
  assign mark_wr_addr = clr_busy ? clr_addr[NODE_W-1:0] : cursor_r;
  assign mark_wr_data = clr_busy ? 1'b0 : walk_mark_wd;

  // ---------------------------------------------------------------
  // State and registered outputs
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    last_r    <= last_nxt;
    ltr_ok_r  <= ltr_ok_nxt;
    slot_r    <= slot_nxt;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      next_free_r <= FREE_W'(1);
      failed_r    <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      next_free_r <= next_free_nxt;
      failed_r    <= failed_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_res_r.found;
  assign out_path_missing = out_res_r.path_missing;
  assign out_pool_full    = out_res_r.pool_full;

endmodule

// ----- sv/tws_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Uses tws_pkg only for consistency; no other dependencies.
module tws_ram
  import tws_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while rd_en is low
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/tws_clear.sv -----
// Post-reset clearing sweep: walks every address once, one per cycle.
// Depends on tws_pkg; drives the write ports of the link and mark RAMs.
module tws_clear
  import tws_pkg::*;
#(
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  output logic [AW-1:0] addr
);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      if (cnt_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign addr = cnt_r;

endmodule

// ----- sv/tws_checker.sv -----
// Port-level checks for trie_word_store_top, attached by bind below.
// Depends on tws_pkg for the field widths.
module tws_checker
  import tws_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_op,
  input logic [LETTER_W-1:0] in_letter,
  input logic                in_word_empty,
  input logic                in_last_letter,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic                out_path_missing,
  input logic                out_pool_full
);

  // offered word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid
      && $stable({in_op, in_letter, in_word_empty, in_last_letter}))
    else $error("input word changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_found, out_path_missing, out_pool_full}))
    else $error("result changed while stalled");

  // a result carries at most one flag
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_found, out_path_missing, out_pool_full}))
    else $error("result flags not exclusive");

  // clearing sweep blocks input right after reset
  a_reset_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing sweep");

  // every word needs its link read (or, if empty, its mark step) before the next one enters
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted back to back");

endmodule

bind trie_word_store_top tws_checker u_tws_checker (.*);

// ----- tb/sv/trie_word_store_top_test.sv -----
// Self-checking test of trie_word_store_top: one word per letter, checked by a
// local prefix-tree predictor. Opens with hand-picked words, then random words, a
// pool-exhaust pass and more random words. Depends on tws_pkg and the RTL only.
`timescale 1ns / 100ps

module trie_word_store_top_test;
  import tws_pkg::*;

  localparam int NODES   = NODE_COUNT_DEF;
  localparam int LETTERS = ALPHABET_SIZE_DEF;
  localparam int NODE_W  = $clog2(NODE_COUNT_DEF);

  // Receiver back-pressure: one long hold once this many results are in.
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS_BEFORE_FILL = 25;
  localparam int RANDOM_WORDS_AFTER_FILL  = 25;

  localparam result_t ANS_HIT     = '{found: 1'b1, path_missing: 1'b0, pool_full: 1'b0};
  localparam result_t ANS_MISS    = '{found: 1'b0, path_missing: 1'b0, pool_full: 1'b0};
  localparam result_t ANS_NO_PATH = '{found: 1'b0, path_missing: 1'b1, pool_full: 1'b0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = OP_INSERT;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                in_word_empty = 1'b0;
  logic                in_last_letter = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic                out_path_missing;
  logic                out_pool_full;

  trie_word_store_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_letter        (in_letter),
    .in_word_empty    (in_word_empty),
    .in_last_letter   (in_last_letter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_path_missing (out_path_missing),
    .out_pool_full    (out_pool_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the tree.
  // A link value of zero means "no child"; node 0 is the root.
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] child_of [NODES*LETTERS];
  bit                marked   [NODES];
  logic [NODE_W-1:0] walk_node;
  logic [NODE_W:0]   next_free;
  bit                walk_broken;    // a letter had no link, or was out of range
  bit                walk_starved;   // insert ran out of nodes

  result_t answers_due [$];          // predicted results, oldest first

  int  words_in;
  int  results_checked;
  int  found_seen;
  int  missing_seen;
  int  full_seen;
  int  mismatches;
  bit  idle_free;                    // both sides run back to back while set

  function automatic int draw_gap();
    return idle_free ? 0 : int'($urandom_range(0, 3));
  endfunction

  // Advances the tree by one word; reports whether a result falls out of it.
  function automatic void trie_walk_step(input op_t op, input logic [LETTER_W-1:0] letter,
                                         input bit empty, input bit last,
                                         output bit answered, output result_t answer);
    int slot;
    logic [NODE_W-1:0] link;
    answered = 1'b0;
    answer   = ANS_MISS;
    if (empty) begin
      // empty word drops any word in progress and acts on the root
      walk_node    = '0;
      walk_broken  = 1'b0;
      walk_starved = 1'b0;
    end else begin
      if (!walk_broken && !walk_starved) begin
        if (letter >= LETTERS) begin
          walk_broken = 1'b1;
        end else begin
          slot = int'(walk_node) * LETTERS + int'(letter);
          link = child_of[slot];
          if (link == '0) begin
            if (op != OP_INSERT) begin
              walk_broken = 1'b1;
            end else if (next_free >= NODES) begin
              walk_starved = 1'b1;
            end else begin
              link = next_free[NODE_W-1:0];
              child_of[slot] = link;
              next_free++;
            end
          end
          if (!walk_broken && !walk_starved) walk_node = link;
        end
      end
      if (!last) return;
    end

    answered = 1'b1;
    if (walk_starved) begin
      answer.pool_full = 1'b1;
    end else if (walk_broken) begin
      answer.path_missing = 1'b1;
    end else begin
      case (op)
        OP_INSERT: begin
          marked[walk_node] = 1'b1;
          answer.found = 1'b1;
        end
        OP_SEARCH: answer.found = marked[walk_node];
        OP_REMOVE: begin
          marked[walk_node] = 1'b0;
          answer.found = 1'b1;
        end
        default: answer.found = 1'b1;
      endcase
    end
    walk_node    = '0;
    walk_broken  = 1'b0;
    walk_starved = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one word, holds it until taken, then feeds the predictor.
  // in_valid stays high between back-to-back words (no drop-and-raise).
  // ---------------------------------------------------------------------------
  task automatic offer_word(input op_t op, input logic [LETTER_W-1:0] letter,
                            input bit empty, input bit last,
                            input bit use_typed, input result_t typed_answer);
    int gap;
    bit answered;
    result_t answer;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_letter      <= letter;
    in_word_empty  <= empty;
    in_last_letter <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trie_walk_step(op, letter, empty, last, answered, answer);
    words_in++;
    if (answered) answers_due.push_back(use_typed ? typed_answer : answer);
    if (words_in % 50 == 0) idle_free = ($urandom_range(0, 3) == 0);
  endtask

  // One random word: mostly short words over a few letters so paths get
  // shared and searches hit; some long words, stray letters past 'z', op
  // switches midway, bare empty words, and words cut short by an empty word.
  task automatic send_random_word();
    op_t op;
    int len;
    int r;
    bit cut;
    logic [LETTER_W-1:0] letter;
    op = op_t'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 6) begin
      offer_word(op, LETTER_W'($urandom_range(0, 31)), 1'b1, 1'($urandom_range(0, 1)),
                 1'b0, ANS_MISS);
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 14))
                                      : int'($urandom_range(1, 5));
    cut = ($urandom_range(0, 99) < 5);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) letter = LETTER_W'($urandom_range(LETTERS, 31));
      else if (r < 70) letter = LETTER_W'($urandom_range(0, 3));
      else letter = LETTER_W'($urandom_range(0, LETTERS - 1));
      if ($urandom_range(0, 99) < 4) op = op_t'($urandom_range(0, 3));
      if (cut && i == len - 1) offer_word(op, letter, 1'b1, 1'b1, 1'b0, ANS_MISS);
      else offer_word(op, letter, 1'b0, i == len - 1, 1'b0, ANS_MISS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Opening words. Rows with typed=1 carry an answer that is plain from the
  // tree's rules; the rest are left to the predictor. Letters: a=0 .. z=25.
  // ---------------------------------------------------------------------------
  typedef struct {
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    bit                  empty;
    bit                  last;
    bit                  typed;
    result_t             answer;
  } word_row_t;

  localparam int OPENING_ROWS = 26;
  word_row_t opening_words [OPENING_ROWS] = '{
    '{OP_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, ANS_MISS},     // root unmarked after reset
    '{OP_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, ANS_HIT},      // empty prefix always there
    '{OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, ANS_NO_PATH},  // "a" on an empty tree
    '{OP_INSERT, 5'd25, 1'b0, 1'b1, 1'b1, ANS_HIT},      // insert "z"
    '{OP_SEARCH, 5'd25, 1'b0, 1'b1, 1'b1, ANS_HIT},
    '{OP_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, ANS_MISS},     // insert "ab"
    '{OP_INSERT, 5'd1,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b0, ANS_MISS},     // "a" is a prefix, not a word
    '{OP_PREFIX, 5'd0,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_INSERT, 5'd31, 1'b0, 1'b1, 1'b1, ANS_NO_PATH},  // past 'z' fails even on insert
    '{OP_SEARCH, 5'd26, 1'b0, 1'b1, 1'b1, ANS_NO_PATH},
    '{OP_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, ANS_MISS},     // bad letter mid-word,
    '{OP_INSERT, 5'd30, 1'b0, 1'b0, 1'b0, ANS_MISS},     // rest of the word skipped
    '{OP_INSERT, 5'd1,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_REMOVE, 5'd0,  1'b0, 1'b0, 1'b0, ANS_MISS},     // remove "ab"
    '{OP_REMOVE, 5'd1,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, ANS_MISS},     // "ab" gone, path kept
    '{OP_SEARCH, 5'd1,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_REMOVE, 5'd16, 1'b0, 1'b1, 1'b1, ANS_NO_PATH},  // remove of absent "q"
    '{OP_INSERT, 5'd2,  1'b0, 1'b0, 1'b0, ANS_MISS},     // op switches mid-word
    '{OP_SEARCH, 5'd3,  1'b0, 1'b1, 1'b0, ANS_MISS},
    '{OP_INSERT, 5'd4,  1'b0, 1'b0, 1'b0, ANS_MISS},     // word in progress...
    '{OP_INSERT, 5'd31, 1'b1, 1'b0, 1'b1, ANS_HIT},      // ...ended by empty insert
    '{OP_SEARCH, 5'd5,  1'b1, 1'b0, 1'b0, ANS_MISS},     // root now marked
    '{OP_REMOVE, 5'd0,  1'b1, 1'b1, 1'b1, ANS_HIT},
    '{OP_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, ANS_MISS}
  };

  // ---------------------------------------------------------------------------
  // Main sequence: reset, opening words, random words, pool exhaust, more
  // random words, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int guard;
    foreach (child_of[i]) child_of[i] = '0;
    foreach (marked[i]) marked[i] = 1'b0;
    walk_node    = '0;
    next_free    = 1;
    walk_broken  = 1'b0;
    walk_starved = 1'b0;
    idle_free    = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing sweep after reset shows up as in_ready held low

    foreach (opening_words[i]) begin
      offer_word(opening_words[i].op, opening_words[i].letter, opening_words[i].empty,
                 opening_words[i].last, opening_words[i].typed, opening_words[i].answer);
    end

    repeat (RANDOM_WORDS_BEFORE_FILL) send_random_word();

    // Exhaust the pool: one long insert down a fresh chain until no node is
    // left, then a couple more letters so the word overflows.
    guard = 0;
    while (next_free < NODES && guard < 2 * NODES) begin
      offer_word(OP_INSERT, LETTER_W'($urandom_range(0, LETTERS - 1)), 1'b0, 1'b0,
                 1'b0, ANS_MISS);
      guard++;
    end
    offer_word(OP_INSERT, LETTER_W'($urandom_range(0, LETTERS - 1)), 1'b0, 1'b0,
               1'b0, ANS_MISS);
    offer_word(OP_INSERT, LETTER_W'($urandom_range(0, LETTERS - 1)), 1'b0, 1'b1,
               1'b0, ANS_MISS);

    // full pool: new inserts overflow, old paths still work
    repeat (RANDOM_WORDS_AFTER_FILL) send_random_word();
    in_valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // extra wait for any stray result

    $display("Covered %0d words in, %0d results out (%0d found, %0d path missing, %0d pool full)",
             words_in, results_checked, found_seen, missing_seen, full_seen);
    $display("Pool nodes used: %0d of %0d; mismatches: %0d", next_free, NODES, mismatches);
    if (mismatches == 0) begin
      $display("PASS trie_word_store_top");
    end else begin
      $display("FAIL trie_word_store_top");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per result, one long hold to back the block up,
  // field-by-field compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    result_t got;
    result_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (results_checked == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);

      got = '{found: out_found, path_missing: out_path_missing, pool_full: out_pool_full};
      results_checked++;
      found_seen   += got.found;
      missing_seen += got.path_missing;
      full_seen    += got.pool_full;
      if (answers_due.size() == 0) begin
        $error("result with no word pending: found %0b path_missing %0b pool_full %0b",
               got.found, got.path_missing, got.pool_full);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, got.found);
          mismatches++;
        end
        if (got.path_missing !== want.path_missing) begin
          $error("path_missing: expected %0b, got %0b", want.path_missing, got.path_missing);
          mismatches++;
        end
        if (got.pool_full !== want.pool_full) begin
          $error("pool_full: expected %0b, got %0b", want.pool_full, got.pool_full);
          mismatches++;
        end
      end
    end
  end

  // Hang guard: far beyond the clearing sweep plus the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("FAIL trie_word_store_top");
    $finish;
  end

endmodule
